### sv/assert_macros.svh
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising clock edge outside reset
`define CHK_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Check that cond never holds outside reset
`define CHK_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

### sv/i2crm_pkg.sv
`default_nettype none

package i2crm_pkg;

	localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd6000;
	localparam logic [7:0]  ADDR_WRITE_MASK   = 8'hfe;
	localparam logic [7:0]  ADDR_READ_BIT     = 8'h01;
	localparam logic [7:0]  BYTE_MSB          = 8'h80;
	localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

	typedef enum logic [1:0] {
		KIND_TICK        = 2'd0,
		KIND_BEGIN_WRITE = 2'd1,
		KIND_BEGIN_READ  = 2'd2,
		KIND_NEXT_BYTE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		FAIL_NONE    = 2'd0,
		FAIL_BUSY    = 2'd1,
		FAIL_START   = 2'd2,
		FAIL_TIMEOUT = 2'd3
	} fail_t;

	typedef enum logic [1:0] {
		STAGE_ADDR = 2'd0,
		STAGE_REG  = 2'd1,
		STAGE_DATA = 2'd2
	} stage_t;

	typedef enum logic [23:0] {
		PH_IDLE      = 24'h000001,
		PH_ST_SDA    = 24'h000002,
		PH_ST_SCL    = 24'h000004,
		PH_ST_CHK    = 24'h000008,
		PH_ST_VFY    = 24'h000010,
		PH_TX_LOW    = 24'h000020,
		PH_TX_DATA   = 24'h000040,
		PH_TX_HIGH   = 24'h000080,
		PH_ACK_LOW   = 24'h000100,
		PH_ACK_REL   = 24'h000200,
		PH_ACK_POLL  = 24'h000400,
		PH_ACK_END   = 24'h000800,
		PH_WAIT_BYTE = 24'h001000,
		PH_RX_REL    = 24'h002000,
		PH_RX_LOW    = 24'h004000,
		PH_RX_HIGH   = 24'h008000,
		PH_RX_SAMPLE = 24'h010000,
		PH_MA_LOW    = 24'h020000,
		PH_MA_DATA   = 24'h040000,
		PH_MA_HIGH   = 24'h080000,
		PH_MA_END    = 24'h100000,
		PH_SP_SDA    = 24'h200000,
		PH_SP_SCL    = 24'h400000,
		PH_SP_REL    = 24'h800000
	} phase_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       need_byte;
		logic       read_valid;
		logic [7:0] read_data;
		logic       done_res;
		logic       failed;
		logic [1:0] fail_reason;
	} res_t;

endpackage

`default_nettype wire

### sv/i2c_register_master.sv
// The result word of a taken input word is registered in the output buffer.
// Throughput: one input word per cycle while in_stall is low; the phase register
// updates on every word. A two-entry output buffer takes one more word while
// one result waits. Reset: arst_n clears the phase to idle, releases both lines,
// empties the buffer and loads ack_timeout with 6000.
`default_nettype none

module i2c_register_master import i2crm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  device_address,
	input  wire logic [7:0]  register_address,
	input  wire logic [7:0]  byte_count,
	input  wire logic [7:0]  write_byte,
	input  wire logic        sda_sample,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             scl_level,
	output logic             sda_level,
	output logic             busy_res,
	output logic             need_byte,
	output logic             read_valid,
	output logic [7:0]       read_data,
	output logic             done_res,
	output logic             failed,
	output logic [1:0]       fail_reason
);

	logic accept;
	logic full;
	res_t res;
	res_t out_res;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	i2crm_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.accept           (accept),
		.kind             (kind),
		.device_address   (device_address),
		.register_address (register_address),
		.byte_count       (byte_count),
		.write_byte       (write_byte),
		.sda_sample       (sda_sample),
		.res              (res)
	);

	i2crm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign scl_level   = out_res.scl_level;
	assign sda_level   = out_res.sda_level;
	assign busy_res    = out_res.busy_res;
	assign need_byte   = out_res.need_byte;
	assign read_valid  = out_res.read_valid;
	assign read_data   = out_res.read_data;
	assign done_res    = out_res.done_res;
	assign failed      = out_res.failed;
	assign fail_reason = out_res.fail_reason;

endmodule

`default_nettype wire

### sv/i2crm_ctrl.sv
`default_nettype none

module i2crm_ctrl import i2crm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        accept,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  device_address,
	input  wire logic [7:0]  register_address,
	input  wire logic [7:0]  byte_count,
	input  wire logic [7:0]  write_byte,
	input  wire logic        sda_sample,
	output res_t             res
);

	logic [15:0] ack_timeout_q;
	phase_t      phase_q, phase_d;
	logic [3:0]  bit_index_q, bit_index_d;
	logic [7:0]  shift_byte_q, shift_byte_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic [15:0] wait_count_q, wait_count_d;
	logic [7:0]  held_device_q, held_device_d;
	logic [7:0]  held_register_q, held_register_d;
	logic        is_read_q, is_read_d;
	logic        second_start_q, second_start_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	stage_t      stage_q, stage_d;
	fail_t       fail_q, fail_d;
	logic        rvalid;
	logic [7:0]  rdata;
	logic        done;
	logic [7:0]  shift_in;
	logic [3:0]  bit_inc;
	logic [7:0]  bytes_dec;
	logic [15:0] wait_dec;
	kind_t       kind_e;

	assign kind_e    = kind_t'(kind);
	assign shift_in  = {shift_byte_q[6:0], sda_sample};
	assign bit_inc   = bit_index_q + 4'd1;
	assign bytes_dec = bytes_left_q - 8'd1;
	assign wait_dec  = wait_count_q - 16'd1;

	always_comb begin
		phase_d         = phase_q;
		bit_index_d     = bit_index_q;
		shift_byte_d    = shift_byte_q;
		bytes_left_d    = bytes_left_q;
		wait_count_d    = wait_count_q;
		held_device_d   = held_device_q;
		held_register_d = held_register_q;
		is_read_d       = is_read_q;
		second_start_d  = second_start_q;
		scl_d           = scl_q;
		sda_d           = sda_q;
		stage_d         = stage_q;
		fail_d          = fail_q;
		rvalid          = 1'b0;
		rdata           = '0;
		done            = 1'b0;
		if (kind_e inside {KIND_BEGIN_WRITE, KIND_BEGIN_READ}) begin
			if (phase_q == PH_IDLE) begin
				is_read_d       = (kind_e == KIND_BEGIN_READ);
				held_device_d   = device_address;
				held_register_d = register_address;
				bytes_left_d    = byte_count;
				second_start_d  = 1'b0;
				fail_d          = FAIL_NONE;
				stage_d         = STAGE_ADDR;
				phase_d         = PH_ST_SDA;
			end
		end else if (kind_e == KIND_NEXT_BYTE) begin
			if (phase_q == PH_WAIT_BYTE) begin
				bytes_left_d = bytes_dec;
				shift_byte_d = write_byte;
				bit_index_d  = '0;
				stage_d      = STAGE_DATA;
				phase_d      = PH_TX_LOW;
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					phase_d = PH_IDLE;
				end
				PH_ST_SDA: begin
					sda_d   = 1'b1;
					phase_d = PH_ST_SCL;
				end
				PH_ST_SCL: begin
					scl_d   = 1'b1;
					phase_d = PH_ST_CHK;
				end
				PH_ST_CHK: begin
					if (!sda_sample) begin
						fail_d  = FAIL_BUSY;
						phase_d = PH_SP_SDA;
					end else begin
						sda_d   = 1'b0;
						phase_d = PH_ST_VFY;
					end
				end
				PH_ST_VFY: begin
					if (sda_sample) begin
						fail_d  = FAIL_START;
						phase_d = PH_SP_SDA;
					end else begin
						shift_byte_d = second_start_q ? (held_device_q | ADDR_READ_BIT)
						                              : (held_device_q & ADDR_WRITE_MASK);
						bit_index_d  = '0;
						stage_d      = STAGE_ADDR;
						phase_d      = PH_TX_LOW;
					end
				end
				PH_TX_LOW: begin
					scl_d   = 1'b0;
					phase_d = PH_TX_DATA;
				end
				PH_TX_DATA: begin
					sda_d   = |(shift_byte_q & BYTE_MSB);
					phase_d = PH_TX_HIGH;
				end
				PH_TX_HIGH: begin
					scl_d        = 1'b1;
					shift_byte_d = {shift_byte_q[6:0], 1'b0};
					bit_index_d  = bit_inc;
					phase_d      = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_TX_LOW;
				end
				PH_ACK_LOW: begin
					scl_d   = 1'b0;
					phase_d = PH_ACK_REL;
				end
				PH_ACK_REL: begin
					sda_d        = 1'b1;
					wait_count_d = ack_timeout_q;
					phase_d      = PH_ACK_POLL;
				end
				PH_ACK_POLL: begin
					if (wait_count_q == '0) begin
						fail_d  = FAIL_TIMEOUT;
						phase_d = PH_SP_SDA;
					end else if (!sda_sample) begin
						scl_d   = 1'b1;
						phase_d = PH_ACK_END;
					end else begin
						wait_count_d = wait_dec;
						if (wait_dec == '0) begin
							fail_d  = FAIL_TIMEOUT;
							phase_d = PH_SP_SDA;
						end
					end
				end
				PH_ACK_END: begin
					scl_d = 1'b0;
					case (stage_q)
						STAGE_ADDR: begin
							if (second_start_q) begin
								if (bytes_left_q == '0) begin
									fail_d  = FAIL_NONE;
									phase_d = PH_SP_SDA;
								end else begin
									shift_byte_d = '0;
									bit_index_d  = '0;
									phase_d      = PH_RX_REL;
								end
							end else begin
								shift_byte_d = held_register_q;
								bit_index_d  = '0;
								stage_d      = STAGE_REG;
								phase_d      = PH_TX_LOW;
							end
						end
						STAGE_REG: begin
							if (is_read_q || bytes_left_q == '0) begin
								fail_d  = FAIL_NONE;
								phase_d = PH_SP_SDA;
							end else begin
								phase_d = PH_WAIT_BYTE;
							end
						end
						default: begin
							if (bytes_left_q == '0) begin
								fail_d  = FAIL_NONE;
								phase_d = PH_SP_SDA;
							end else begin
								phase_d = PH_WAIT_BYTE;
							end
						end
					endcase
				end
				PH_WAIT_BYTE: begin
					phase_d = PH_IDLE;
				end
				PH_RX_REL: begin
					sda_d   = 1'b1;
					phase_d = PH_RX_LOW;
				end
				PH_RX_LOW: begin
					scl_d   = 1'b0;
					phase_d = PH_RX_HIGH;
				end
				PH_RX_HIGH: begin
					scl_d   = 1'b1;
					phase_d = PH_RX_SAMPLE;
				end
				PH_RX_SAMPLE: begin
					shift_byte_d = shift_in;
					bit_index_d  = bit_inc;
					if (bit_inc >= BITS_PER_BYTE) begin
						rvalid  = 1'b1;
						rdata   = shift_in;
						phase_d = PH_MA_LOW;
					end else begin
						phase_d = PH_RX_LOW;
					end
				end
				PH_MA_LOW: begin
					scl_d   = 1'b0;
					phase_d = PH_MA_DATA;
				end
				PH_MA_DATA: begin
					sda_d   = (bytes_left_q == 8'd1);
					phase_d = PH_MA_HIGH;
				end
				PH_MA_HIGH: begin
					scl_d   = 1'b1;
					phase_d = PH_MA_END;
				end
				PH_MA_END: begin
					scl_d        = 1'b0;
					bytes_left_d = bytes_dec;
					if (bytes_dec == '0) begin
						fail_d  = FAIL_NONE;
						phase_d = PH_SP_SDA;
					end else begin
						shift_byte_d = '0;
						bit_index_d  = '0;
						phase_d      = PH_RX_REL;
					end
				end
				PH_SP_SDA: begin
					sda_d   = 1'b0;
					phase_d = PH_SP_SCL;
				end
				PH_SP_SCL: begin
					scl_d   = 1'b1;
					phase_d = PH_SP_REL;
				end
				PH_SP_REL: begin
					sda_d = 1'b1;
					if (fail_q == FAIL_NONE && is_read_q && !second_start_q
					    && stage_q == STAGE_REG) begin
						second_start_d = 1'b1;
						phase_d        = PH_ST_SDA;
					end else begin
						done    = 1'b1;
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res.scl_level   = scl_d;
		res.sda_level   = sda_d;
		res.busy_res    = (phase_d != PH_IDLE);
		res.need_byte   = (phase_d == PH_WAIT_BYTE);
		res.read_valid  = rvalid;
		res.read_data   = rdata;
		res.done_res    = done;
		res.failed      = done && (fail_q != FAIL_NONE);
		res.fail_reason = done ? fail_q : FAIL_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= ACK_TIMEOUT_RESET;
		end else if (cfg_we) begin
			ack_timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			bit_index_q     <= '0;
			shift_byte_q    <= '0;
			bytes_left_q    <= '0;
			wait_count_q    <= '0;
			held_device_q   <= '0;
			held_register_q <= '0;
			is_read_q       <= 1'b0;
			second_start_q  <= 1'b0;
			scl_q           <= 1'b1;
			sda_q           <= 1'b1;
			stage_q         <= STAGE_ADDR;
			fail_q          <= FAIL_NONE;
		end else if (accept) begin
			phase_q         <= phase_d;
			bit_index_q     <= bit_index_d;
			shift_byte_q    <= shift_byte_d;
			bytes_left_q    <= bytes_left_d;
			wait_count_q    <= wait_count_d;
			held_device_q   <= held_device_d;
			held_register_q <= held_register_d;
			is_read_q       <= is_read_d;
			second_start_q  <= second_start_d;
			scl_q           <= scl_d;
			sda_q           <= sda_d;
			stage_q         <= stage_d;
			fail_q          <= fail_d;
		end
	end

endmodule

`default_nettype wire

### sv/i2crm_out_buf.sv
`default_nettype none

module i2crm_out_buf import i2crm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t push_data,
	output logic      full,
	output logic      out_valid,
	input  wire logic out_stall,
	output res_t      out_data
);

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;
	logic take;
	logic main_free;

	assign take      = main_valid_q && !out_stall;
	assign main_free = !main_valid_q || take;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end
		if (push && !main_free) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

### sv/i2crm_checker.sv
`default_nettype none
`include "assert_macros.svh"

module i2crm_checker import i2crm_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        scl_level,
	input wire logic        sda_level,
	input wire logic        busy_res,
	input wire logic        need_byte,
	input wire logic        read_valid,
	input wire logic [7:0]  read_data,
	input wire logic        done_res,
	input wire logic        failed,
	input wire logic [1:0]  fail_reason
);

	`CHK_ASSERT(a_out_hold, clk, arst_n,
		out_valid && out_stall |=> out_valid && $stable(scl_level) && $stable(sda_level)
		&& $stable(read_data) && $stable(done_res))
	`CHK_ASSERT(a_stall_has_word, clk, arst_n, in_stall |-> out_valid)
	`CHK_ASSERT(a_fail_ends, clk, arst_n,
		out_valid && fail_reason != FAIL_NONE |-> failed && done_res && !busy_res)
	`CHK_NEVER(a_read_in_xfer, clk, arst_n,
		out_valid && read_valid && (done_res || !busy_res || need_byte))

endmodule

bind i2c_register_master i2crm_checker u_i2crm_checker (.*);

`default_nettype wire
